[hw/rtl/ist_pkg.sv]
`timescale 1ns / 1ps
package ist_pkg;

   localparam int MAX_INTERVALS = 64;
   localparam int IDX_W   = $clog2(MAX_INTERVALS);
   localparam int CNT_W   = $clog2(MAX_INTERVALS + 1);
   localparam int WCNT_W  = $clog2(MAX_INTERVALS + 3);
   localparam int ADDR_W  = IDX_W + 1;
   localparam int MEM_DEPTH = 2 ** ADDR_W;
   localparam int VAL_W   = 32;
   localparam int ENTRY_W = 2 * VAL_W;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic [1:0]       operation;
      logic [VAL_W-1:0] range_low;
      logic [VAL_W-1:0] range_high;
   } req_type;

   typedef struct packed {
      logic       covered;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_PROC  = 6'b000100,
      ST_WR2   = 6'b001000,
      ST_FINAL = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

endpackage

[hw/rtl/interval_set_table.sv]
`timescale 1ns / 1ps
// An invalid request answers without reading the table; a query or remove walks the
// N stored intervals, and an add walks them and then writes its merged range unless
// it was already placed before a later entry. That placement, or a remove that splits
// an entry, takes one extra write. One request at a time: req_stall holds off new
// requests while busy, and the single read port of the table RAM walks every stored
// entry once per valid request. Reset empties the table at once (count cleared, no sweep).
module interval_set_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ist_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ist_pkg::rsp_type rsp_data
);
   import ist_pkg::*;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [WCNT_W-1:0] k_ff, k_in;
   logic              act_ff, act_in;
   logic              placed_ff, placed_in;
   logic              cov_ff, cov_in;
   logic [VAL_W-1:0]  ms_ff, ms_in, me_ff, me_in;
   logic [VAL_W-1:0]  pend_s_ff, pend_s_in, pend_e_ff, pend_e_in;
   logic [1:0]        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic               wr_want, wr_en, rd_en;
   logic [VAL_W-1:0]   wr_s, wr_e, ent_s, ent_e;
   logic [ENTRY_W-1:0] rd_data;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic               out_free;

   assign ent_s    = rd_data[ENTRY_W-1:VAL_W];
   assign ent_e    = rd_data[VAL_W-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign wr_en    = wr_want && (k_ff < WCNT_W'(MAX_INTERVALS));
   assign wr_addr  = {!act_ff, k_ff[IDX_W-1:0]};
   assign rd_addr  = {act_ff, idx_ff[IDX_W-1:0]};

   ist_ram #(.WIDTH(ENTRY_W), .DEPTH(MEM_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({wr_s, wr_e}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      act_in       = act_ff;
      placed_in    = placed_ff;
      cov_in       = cov_ff;
      ms_in        = ms_ff;
      me_in        = me_ff;
      pend_s_in    = pend_s_ff;
      pend_e_in    = pend_e_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_want      = 1'b0;
      wr_s         = ent_s;
      wr_e         = ent_e;
      rd_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               idx_in    = '0;
               k_in      = '0;
               placed_in = 1'b0;
               cov_in    = 1'b0;
               ms_in     = req_data.range_low;
               me_in     = req_data.range_high;
               status_in = STATUS_OK;
               if (req_data.range_low >= req_data.range_high ||
                   !(req_data.operation == OP_ADD || req_data.operation == OP_QUERY ||
                     req_data.operation == OP_REMOVE)) begin
                  status_in = STATUS_INVALID;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (idx_ff == count_ff) begin
               state_in = (req_ff.operation == OP_ADD) ? ST_FINAL : ST_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_PROC;
            end
         end
         ST_PROC: begin
            idx_in   = idx_ff + 1'b1;
            state_in = ST_READ;
            case (req_ff.operation)
               OP_ADD: begin
                  if (ent_e < req_ff.range_low) begin
                     wr_want = 1'b1;
                     k_in    = k_ff + 1'b1;
                  end else if (ent_s > req_ff.range_high) begin
                     wr_want = 1'b1;
                     k_in    = k_ff + 1'b1;
                     if (!placed_ff) begin
                        // emit the merged range first, hold this entry for the next cycle
                        wr_s      = ms_ff;
                        wr_e      = me_ff;
                        placed_in = 1'b1;
                        pend_s_in = ent_s;
                        pend_e_in = ent_e;
                        state_in  = ST_WR2;
                     end
                  end else begin
                     if (ent_s < ms_ff) ms_in = ent_s;
                     if (ent_e > me_ff) me_in = ent_e;
                  end
               end
               OP_QUERY: begin
                  if (ent_s <= req_ff.range_low && ent_e >= req_ff.range_high) begin
                     cov_in = 1'b1;
                  end
               end
               default: begin
                  if (ent_e <= req_ff.range_low || ent_s >= req_ff.range_high) begin
                     wr_want = 1'b1;
                     k_in    = k_ff + 1'b1;
                  end else if (ent_s < req_ff.range_low) begin
                     wr_want = 1'b1;
                     wr_e    = req_ff.range_low;
                     k_in    = k_ff + 1'b1;
                     if (ent_e > req_ff.range_high) begin
                        pend_s_in = req_ff.range_high;
                        pend_e_in = ent_e;
                        state_in  = ST_WR2;
                     end
                  end else if (ent_e > req_ff.range_high) begin
                     wr_want = 1'b1;
                     wr_s    = req_ff.range_high;
                     k_in    = k_ff + 1'b1;
                  end
               end
            endcase
         end
         ST_WR2: begin
            wr_want  = 1'b1;
            wr_s     = pend_s_ff;
            wr_e     = pend_e_ff;
            k_in     = k_ff + 1'b1;
            state_in = ST_READ;
         end
         ST_FINAL: begin
            if (!placed_ff) begin
               wr_want = 1'b1;
               wr_s    = ms_ff;
               wr_e    = me_ff;
               k_in    = k_ff + 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.covered = cov_ff;
               rsp_in.status  = status_ff;
               if (status_ff == STATUS_OK &&
                   (req_ff.operation == OP_ADD || req_ff.operation == OP_REMOVE)) begin
                  if (k_ff > WCNT_W'(MAX_INTERVALS)) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     // swap banks: the freshly written list becomes the table
                     act_in   = !act_ff;
                     count_in = k_ff[CNT_W-1:0];
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      k_ff      <= k_in;
      placed_ff <= placed_in;
      cov_ff    <= cov_in;
      ms_ff     <= ms_in;
      me_ff     <= me_in;
      pend_s_ff <= pend_s_in;
      pend_e_ff <= pend_e_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_INTERVALS))
      else $error("interval count above capacity");

   a_done_hands_off: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("finished item not handed to output register");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (idx_ff <= count_ff))
      else $error("table walk passed the stored count");
`endif

endmodule

[hw/rtl/ist_ram.sv]
`timescale 1ns / 1ps
module ist_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
